// ===== rtl/itch_to_moldudp64_framer_core_macros.svh =====
// assertion macros for the itch to moldudp64 framer
`ifndef ITCH_TO_MOLDUDP64_FRAMER_CORE_MACROS_SVH
`define ITCH_TO_MOLDUDP64_FRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/imf_pkg.sv =====
// shared types, constants and tables of the itch to moldudp64 framer
package imf_pkg;

  localparam int unsigned MAX_MESSAGE_LEN_DEF = 1002;
  localparam int unsigned FIFO_DEPTH_DEF      = 4;

  localparam int unsigned IDX_W = 5;
  // header word positions: session 0..9, sequence 10..17, count 18..19, length 20..21, type 22
  localparam logic [IDX_W-1:0] SESSION_LAST = 5'd9;
  localparam logic [IDX_W-1:0] SEQ_LAST     = 5'd17;
  localparam logic [IDX_W-1:0] CNT_HI_IDX   = 5'd18;
  localparam logic [IDX_W-1:0] CNT_LO_IDX   = 5'd19;
  localparam logic [IDX_W-1:0] LEN_HI_IDX   = 5'd20;
  localparam logic [IDX_W-1:0] LEN_LO_IDX   = 5'd21;
  localparam logic [IDX_W-1:0] TYPE_IDX     = 5'd22;

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_EMIT,
    PH_DROP,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_BYTE,
    CMD_ABORT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] len;
    logic [63:0] seq;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

  function automatic logic [7:0] session_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h53;
      4'd1:    b = 8'h45;
      4'd2:    b = 8'h53;
      4'd3:    b = 8'h53;
      4'd4:    b = 8'h49;
      4'd5:    b = 8'h4f;
      4'd6:    b = 8'h4e;
      4'd7:    b = 8'h20;
      4'd8:    b = 8'h20;
      4'd9:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // accepted codes A F E C X D U P S H
  function automatic logic type_ok(input logic [7:0] t);
    logic ok;
    case (t)
      8'h41, 8'h46, 8'h45, 8'h43, 8'h58,
      8'h44, 8'h55, 8'h50, 8'h53, 8'h48: ok = 1'b1;
      default:                           ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/itch_to_moldudp64_framer_core.sv =====
// top level of the itch to moldudp64 framer
// Takes input words on the slave side. Each accepted message type byte expands into 23 output
// words (22 header bytes plus the type byte), every later message byte into one word, and the
// emitter sends one word per cycle while the master side is ready; a message word reaches the
// master side via a queue entry and the emitter's command register. A queue of FIFO_DEPTH
// commands separates the parser from the emitter, so input is taken every cycle, header burst
// or not, until the queue fills; the 22 header words set the pace for accepted messages,
// while length bytes and dropped messages go in at one word per cycle. A word with tlast set
// ends the stream; a bad length or end of stream halts the block until reset.
module itch_to_moldudp64_framer_core #(
  parameter int unsigned MAX_MESSAGE_LEN = imf_pkg::MAX_MESSAGE_LEN_DEF,
  parameter int unsigned FIFO_DEPTH      = imf_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,   // start_sequence
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,  // last
  output logic        m_axis_tuser   // abort
);

  imf_pkg::cmd_t push_cmd, pop_cmd;
  logic [imf_pkg::CMD_W-1:0] pop_raw;
  logic push, pop, full, empty, in_fire;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pop_cmd       = imf_pkg::cmd_t'(pop_raw);

  imf_front #(
    .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_fire_i  (in_fire),
    .in_byte_i  (s_axis_tdata),
    .in_eos_i   (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  imf_fifo #(
    .WIDTH(imf_pkg::CMD_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(pop_raw),
    .empty_o(empty)
  );

  imf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_o (m_axis_tdata),
    .m_tlast_o (m_axis_tlast),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

// ===== rtl/imf_fifo.sv =====
// small register queue carrying commands from the parser to the emitter
module imf_fifo #(
  parameter int unsigned WIDTH = imf_pkg::CMD_W,
  parameter int unsigned DEPTH = imf_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/imf_front.sv =====
// input parser: length prefix, type filter and sequence tracking
module imf_front #(
  parameter int unsigned MAX_MESSAGE_LEN = imf_pkg::MAX_MESSAGE_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  input  logic          in_fire_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_eos_i,
  output logic          push_o,
  output imf_pkg::cmd_t cmd_o
);

  localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_LEN + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_MESSAGE_LEN);

  imf_pkg::phase_e phase_q, phase_d;
  logic [LEN_W-1:0] msg_len_q, msg_len_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [63:0]      seq_q, seq_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [15:0]      len_full;
  logic [LEN_W-1:0] rem_dec;

  assign len_full = {len_hi_q, in_byte_i};

  always_comb begin
    phase_d  = phase_q;
    msg_len_d = msg_len_q;
    rem_d    = rem_q;
    seq_d    = seq_q;
    len_hi_d = len_hi_q;
    push_o   = 1'b0;
    cmd_o.kind = imf_pkg::CMD_BYTE;
    cmd_o.data = in_byte_i;
    cmd_o.last = 1'b0;
    cmd_o.len  = 16'(msg_len_q);
    cmd_o.seq  = seq_q;
    rem_dec  = rem_q - 1'b1;
    if (phase_q == imf_pkg::PH_TYPE) begin
      rem_dec = msg_len_q - 1'b1;
    end
    if (in_fire_i && phase_q != imf_pkg::PH_HALT) begin
      if (in_eos_i) begin
        if (phase_q == imf_pkg::PH_EMIT) begin
          push_o     = 1'b1;
          cmd_o.kind = imf_pkg::CMD_ABORT;
          cmd_o.data = 8'h00;
          cmd_o.last = 1'b1;
        end
        phase_d = imf_pkg::PH_HALT;
      end else begin
        case (phase_q)
          imf_pkg::PH_LEN_HI: begin
            len_hi_d = in_byte_i;
            phase_d  = imf_pkg::PH_LEN_LO;
          end
          imf_pkg::PH_LEN_LO: begin
            if (len_full == 16'd0 || len_full > MAX_LEN) begin
              phase_d = imf_pkg::PH_HALT;
            end else begin
              msg_len_d = LEN_W'(len_full);
              rem_d     = LEN_W'(len_full);
              phase_d   = imf_pkg::PH_TYPE;
            end
          end
          imf_pkg::PH_TYPE: begin
            rem_d = rem_dec;
            if (imf_pkg::type_ok(in_byte_i)) begin
              push_o     = 1'b1;
              cmd_o.kind = imf_pkg::CMD_HEADER;
              cmd_o.last = (rem_dec == '0);
              if (rem_dec == '0) begin
                seq_d   = seq_q + 64'd1;
                phase_d = imf_pkg::PH_LEN_HI;
              end else begin
                phase_d = imf_pkg::PH_EMIT;
              end
            end else begin
              phase_d = (rem_dec == '0) ? imf_pkg::PH_LEN_HI : imf_pkg::PH_DROP;
            end
          end
          imf_pkg::PH_EMIT: begin
            rem_d      = rem_dec;
            push_o     = 1'b1;
            cmd_o.last = (rem_dec == '0);
            if (rem_dec == '0) begin
              seq_d   = seq_q + 64'd1;
              phase_d = imf_pkg::PH_LEN_HI;
            end
          end
          imf_pkg::PH_DROP: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = imf_pkg::PH_LEN_HI;
            end
          end
          default: begin
            phase_d = imf_pkg::PH_HALT;
          end
        endcase
      end
    end
    if (cfg_we_i) begin
      seq_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= imf_pkg::PH_LEN_HI;
      msg_len_q <= '0;
      rem_q     <= '0;
      seq_q     <= 64'd1;
      len_hi_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      msg_len_q <= msg_len_d;
      rem_q     <= rem_d;
      seq_q     <= seq_d;
      len_hi_q  <= len_hi_d;
    end
  end

endmodule

// ===== rtl/imf_back.sv =====
// packet emitter: expands header commands into 23 words, passes message bytes, emits abort words
`include "itch_to_moldudp64_framer_core_macros.svh"

module imf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  imf_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic          m_tlast_o,
  output logic          m_tuser_o
);

  imf_pkg::cmd_t cmd_q, cmd_d;
  logic          cmd_valid_q, cmd_valid_d;
  logic [imf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [2:0]    seq_sel;
  logic          done;
  logic          fire;

  assign seq_sel = 3'(imf_pkg::SEQ_LAST - idx_q);
  assign fire    = cmd_valid_q && m_tready_i;
  assign m_tvalid_o = cmd_valid_q;

  always_comb begin
    m_tdata_o = 8'h00;
    m_tlast_o = 1'b0;
    m_tuser_o = 1'b0;
    done      = 1'b1;
    case (cmd_q.kind)
      imf_pkg::CMD_HEADER: begin
        done = (idx_q == imf_pkg::TYPE_IDX);
        if (idx_q <= imf_pkg::SESSION_LAST) begin
          m_tdata_o = imf_pkg::session_byte(idx_q[3:0]);
        end else if (idx_q <= imf_pkg::SEQ_LAST) begin
          m_tdata_o = cmd_q.seq[{seq_sel, 3'b000} +: 8];
        end else if (idx_q == imf_pkg::CNT_HI_IDX) begin
          m_tdata_o = 8'h00;
        end else if (idx_q == imf_pkg::CNT_LO_IDX) begin
          m_tdata_o = 8'h01;
        end else if (idx_q == imf_pkg::LEN_HI_IDX) begin
          m_tdata_o = cmd_q.len[15:8];
        end else if (idx_q == imf_pkg::LEN_LO_IDX) begin
          m_tdata_o = cmd_q.len[7:0];
        end else begin
          m_tdata_o = cmd_q.data;
          m_tlast_o = cmd_q.last;
        end
      end
      imf_pkg::CMD_BYTE: begin
        m_tdata_o = cmd_q.data;
        m_tlast_o = cmd_q.last;
      end
      imf_pkg::CMD_ABORT: begin
        m_tlast_o = 1'b1;
        m_tuser_o = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    pop_o       = !empty_i && (!cmd_valid_q || (fire && done));
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cmd_d       = cmd_i;
      cmd_valid_d = 1'b1;
      idx_d       = '0;
    end else if (fire && done) begin
      cmd_valid_d = 1'b0;
      idx_d       = '0;
    end else if (fire) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  `IMF_ASSERT_NOW(a_idx_range, 1'b1, idx_q <= imf_pkg::TYPE_IDX, "header index out of range")
  `IMF_ASSERT_NOW(a_idx_single, cmd_valid_q && cmd_q.kind != imf_pkg::CMD_HEADER, idx_q == '0, "single word command with nonzero index")
  `IMF_ASSERT_NOW(a_abort_last, cmd_valid_q && m_tuser_o, m_tlast_o && m_tdata_o == 8'h00, "abort word malformed")
  `IMF_ASSERT_NEXT(a_stall_idx, cmd_valid_q && !m_tready_i, $stable(idx_q) && cmd_valid_q, "index moved while stalled")

endmodule

// ===== bench/tb_itch_to_moldudp64_framer_core.sv =====
// self-checking testbench of the itch to moldudp64 framer core
`timescale 1ns / 100ps

module tb_itch_to_moldudp64_framer_core;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 190;
  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned MAX_LEN      = imf_pkg::MAX_MESSAGE_LEN_DEF;

  localparam logic [79:0] SESSION_ID = "SESSION  1";
  localparam logic [7:0]  ACCEPTED_CODES [10] = '{"A", "F", "E", "C", "X",
                                                  "D", "U", "P", "S", "H"};

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_last;
    logic       pkt_abort;
  } packet_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tlast = 1'b0; // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;        // last
  logic        m_axis_tuser;        // abort

  packet_word_t    pending_packet_words [$];
  imf_pkg::phase_e frm_phase = imf_pkg::PH_LEN_HI;
  logic [9:0]      frm_len = '0;
  logic [9:0]      frm_left = '0;
  logic [7:0]      frm_len_hi = '0;
  logic [63:0]     next_seq = 64'd1;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned src_max_gap = MAX_GAP;
  int unsigned snk_max_gap = MAX_GAP;

  itch_to_moldudp64_framer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic is_accepted_code(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (ACCEPTED_CODES[i] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [7:0] random_dropped_code();
    logic [7:0] code;
    do code = 8'($urandom_range(0, 255)); while (is_accepted_code(code));
    return code;
  endfunction

  function automatic void expect_word(input logic [7:0] data, input logic lst,
                                      input logic abt);
    packet_word_t w;
    w.data      = data;
    w.pkt_last  = lst;
    w.pkt_abort = abt;
    pending_packet_words.push_back(w);
  endfunction

  // framing behavior for one accepted input word
  function automatic void predict_framer(input logic [7:0] b, input logic eos);
    logic [15:0] len;
    if (frm_phase == imf_pkg::PH_HALT) return;
    if (eos) begin
      if (frm_phase == imf_pkg::PH_EMIT) expect_word(8'h00, 1'b1, 1'b1);
      frm_phase = imf_pkg::PH_HALT;
      return;
    end
    case (frm_phase)
      imf_pkg::PH_LEN_HI: begin
        frm_len_hi = b;
        frm_phase  = imf_pkg::PH_LEN_LO;
      end
      imf_pkg::PH_LEN_LO: begin
        len = {frm_len_hi, b};
        if (len == 16'd0 || len > MAX_LEN) begin
          frm_phase = imf_pkg::PH_HALT;
        end else begin
          frm_len   = len[9:0];
          frm_left  = len[9:0];
          frm_phase = imf_pkg::PH_TYPE;
        end
      end
      imf_pkg::PH_TYPE: begin
        frm_left = frm_len - 10'd1;
        if (is_accepted_code(b)) begin
          for (int i = 0; i < 10; i++) expect_word(SESSION_ID[8*(9-i) +: 8], 1'b0, 1'b0);
          for (int i = 7; i >= 0; i--) expect_word(next_seq[8*i +: 8], 1'b0, 1'b0);
          expect_word(8'h00, 1'b0, 1'b0);
          expect_word(8'h01, 1'b0, 1'b0);
          expect_word({6'd0, frm_len[9:8]}, 1'b0, 1'b0);
          expect_word(frm_len[7:0], 1'b0, 1'b0);
          expect_word(b, frm_left == 10'd0, 1'b0);
          if (frm_left == 10'd0) begin
            next_seq++;
            frm_phase = imf_pkg::PH_LEN_HI;
          end else begin
            frm_phase = imf_pkg::PH_EMIT;
          end
        end else begin
          frm_phase = (frm_left == 10'd0) ? imf_pkg::PH_LEN_HI : imf_pkg::PH_DROP;
        end
      end
      imf_pkg::PH_EMIT: begin
        frm_left--;
        expect_word(b, frm_left == 10'd0, 1'b0);
        if (frm_left == 10'd0) begin
          next_seq++;
          frm_phase = imf_pkg::PH_LEN_HI;
        end
      end
      imf_pkg::PH_DROP: begin
        frm_left--;
        if (frm_left == 10'd0) frm_phase = imf_pkg::PH_LEN_HI;
      end
      default: frm_phase = imf_pkg::PH_HALT;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin : monitor
    packet_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) next_seq = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_framer(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_packet_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b abort %b",
                                    m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end else begin
          want = pending_packet_words.pop_front();
          if (m_axis_tdata !== want.data)
            report_mismatch($sformatf("byte %h, want %h", m_axis_tdata, want.data));
          if (m_axis_tlast !== want.pkt_last)
            report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.pkt_last));
          if (m_axis_tuser !== want.pkt_abort)
            report_mismatch($sformatf("abort %b, want %b", m_axis_tuser, want.pkt_abort));
        end
      end
    end
  end

  // downstream stall pattern
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, snk_max_gap);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  // length prefix, then the first upto bytes of the message
  task automatic send_message(input int unsigned len, input logic [7:0] code,
                              input int unsigned upto);
    logic [15:0] len16;
    len16 = len[15:0];
    send_word(len16[15:8], 1'b0);
    send_word(len16[7:0], 1'b0);
    if (upto > 0) send_word(code, 1'b0);
    for (int unsigned i = 1; i < upto; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_packet_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_start_sequence(input logic [63:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_accepted_types();
    for (int i = 0; i < 10; i++) send_message(i % 3 + 1, ACCEPTED_CODES[i], i % 3 + 1);
  endtask

  task automatic test_dropped_types();
    send_message(1, 8'h00, 1);
    send_message(3, 8'hff, 3);
    send_message(2, "B", 2);
    send_message(1, 8'h7f, 1);
    send_message(2, "A", 2);
  endtask

  task automatic test_sequence_wrap();
    write_start_sequence(64'hffff_ffff_ffff_ffff);
    send_message(1, "S", 1);
    send_message(2, "H", 2);
    write_start_sequence(64'h0);
    send_message(1, "P", 1);
    write_start_sequence(64'h0000_0000_ffff_ffff);
    send_message(1, "X", 1);
    send_message(1, "C", 1);
  endtask

  task automatic test_random_traffic();
    int unsigned first_word;
    int unsigned msg_count;
    int unsigned len;
    int unsigned r;
    logic [63:0] seq_value;
    first_word = words_sent;
    msg_count  = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      if (msg_count % 8 == 7) begin
        case ($urandom_range(0, 5))
          0:       seq_value = 64'h0;
          1:       seq_value = 64'hffff_ffff_ffff_ffff;
          2:       seq_value = 64'hffff_ffff_ffff_fffe;
          3:       seq_value = 64'h8000_0000_0000_0000;
          4:       seq_value = 64'h0000_0000_ffff_ffff;
          default: seq_value = {$urandom, $urandom};
        endcase
        write_start_sequence(seq_value);
      end
      case ($urandom_range(0, 3))
        0: begin src_max_gap = 0;       snk_max_gap = 0;       end
        1: begin src_max_gap = MAX_GAP; snk_max_gap = MAX_GAP; end
        2: begin src_max_gap = MAX_GAP; snk_max_gap = 0;       end
        default: begin src_max_gap = 0; snk_max_gap = MAX_GAP; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 40) len = $urandom_range(1, 4);
      else if (r < 90) len = $urandom_range(5, 40);
      else len = $urandom_range(41, 100);
      if ($urandom_range(0, 4) == 0) send_message(len, random_dropped_code(), len);
      else send_message(len, ACCEPTED_CODES[$urandom_range(0, 9)], len);
      msg_count++;
    end
    src_max_gap = MAX_GAP;
    snk_max_gap = MAX_GAP;
  endtask

  // the stream can end only once per reset, so one ending is picked
  task automatic test_stream_end();
    int unsigned len;
    int unsigned upto;
    case ($urandom_range(0, 5))
      3: begin
        len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 65535);
        send_message(len, 8'h00, 0);
      end
      4: begin
        if ($urandom_range(0, 1)) send_word(8'h00, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      5: begin
        len = $urandom_range(3, 20);
        send_message(len, random_dropped_code(), $urandom_range(1, len - 1));
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        // longest length half of the time, cut short by the end of stream
        len  = $urandom_range(0, 1) ? MAX_LEN : $urandom_range(2, 40);
        upto = $urandom_range(1, (len - 1 < 30) ? len - 1 : 30);
        send_message(len, ACCEPTED_CODES[$urandom_range(0, 9)], upto);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    wait_idle();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_accepted_types();
    test_dropped_types();
    test_sequence_wrap();
    test_random_traffic();
    test_stream_end();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/imf_pkg.sv
rtl/imf_fifo.sv
rtl/imf_front.sv
rtl/imf_back.sv
rtl/itch_to_moldudp64_framer_core.sv
bench/tb_itch_to_moldudp64_framer_core.sv
